// ----- hw/rtl/fma_pkg.sv -----
// Shared types, constants and mass table for the formula mass accumulator.
package fma_pkg;

  localparam int COUNT_BITS    = 20;
  localparam int FRACTION_BITS = 24;
  localparam int TOTAL_BITS    = 63;
  localparam int MASS_BITS     = FRACTION_BITS + 6;
  localparam int PROD_BITS     = MASS_BITS + COUNT_BITS;
  localparam int PROD_EXT_BITS = (PROD_BITS > TOTAL_BITS) ? PROD_BITS : TOTAL_BITS;
  localparam int SUM_BITS      = TOTAL_BITS + 2;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 1;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [63:0]           DEC9      = 64'd1000000000;

  localparam logic [CFG_IDX_BITS-1:0] REG_MASS_KIND      = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEAVY_NITROGEN = 1'd1;

  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_P = 8'h50;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_NAME  = 4'b0010,
    PH_COUNT = 4'b0100,
    PH_SKIP  = 4'b1000
  } phase_t;

  // Beat leaving the parser: up to two atoms to be weighed and summed.
  typedef struct packed {
    logic [MASS_BITS-1:0]  mass_a;
    logic [COUNT_BITS-1:0] count_a;
    logic [MASS_BITS-1:0]  mass_b;
    logic [COUNT_BITS-1:0] count_b;
    logic                  last;
    logic                  ovf;
  } commit_t;

  // Beat leaving the multiplier stage.
  typedef struct packed {
    logic [PROD_BITS-1:0] prod_a;
    logic [PROD_BITS-1:0] prod_b;
    logic                 last;
    logic                 ovf;
  } product_t;

  function automatic logic [63:0] to_fixed(input logic [63:0] ip, input logic [63:0] frac9);
    return (ip << FRACTION_BITS) + (((frac9 << FRACTION_BITS) + DEC9 / 2) / DEC9);
  endfunction

  localparam logic [MASS_BITS-1:0] M_H_MONO   = MASS_BITS'(to_fixed(64'd1, 64'd7825035));
  localparam logic [MASS_BITS-1:0] M_O_MONO   = MASS_BITS'(to_fixed(64'd15, 64'd994914630));
  localparam logic [MASS_BITS-1:0] M_N_MONO   = MASS_BITS'(to_fixed(64'd14, 64'd3074000));
  localparam logic [MASS_BITS-1:0] M_N15_MONO = MASS_BITS'(to_fixed(64'd15, 64'd74000));
  localparam logic [MASS_BITS-1:0] M_C_MONO   = MASS_BITS'(to_fixed(64'd12, 64'd0));
  localparam logic [MASS_BITS-1:0] M_S_MONO   = MASS_BITS'(to_fixed(64'd31, 64'd972070700));
  localparam logic [MASS_BITS-1:0] M_P_MONO   = MASS_BITS'(to_fixed(64'd30, 64'd973762000));
  localparam logic [MASS_BITS-1:0] M_H_AVG    = MASS_BITS'(to_fixed(64'd1, 64'd7940000));
  localparam logic [MASS_BITS-1:0] M_O_AVG    = MASS_BITS'(to_fixed(64'd15, 64'd999400000));
  localparam logic [MASS_BITS-1:0] M_N_AVG    = MASS_BITS'(to_fixed(64'd14, 64'd6700000));
  localparam logic [MASS_BITS-1:0] M_N15_AVG  = MASS_BITS'(to_fixed(64'd15, 64'd3740000));
  localparam logic [MASS_BITS-1:0] M_C_AVG    = MASS_BITS'(to_fixed(64'd12, 64'd10700000));
  localparam logic [MASS_BITS-1:0] M_S_AVG    = MASS_BITS'(to_fixed(64'd32, 64'd65000000));
  localparam logic [MASS_BITS-1:0] M_P_AVG    = MASS_BITS'(to_fixed(64'd30, 64'd973761000));

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [MASS_BITS-1:0] mass_lookup(input logic [7:0] first,
                                                       input logic       is_long,
                                                       input logic       avg,
                                                       input logic       heavy);
    logic [MASS_BITS-1:0] m;
    case (first)
      CH_H:    m = avg ? M_H_AVG : M_H_MONO;
      CH_O:    m = avg ? M_O_AVG : M_O_MONO;
      CH_N:    m = heavy ? (avg ? M_N15_AVG : M_N15_MONO) : (avg ? M_N_AVG : M_N_MONO);
      CH_C:    m = avg ? M_C_AVG : M_C_MONO;
      CH_S:    m = avg ? M_S_AVG : M_S_MONO;
      CH_P:    m = avg ? M_P_AVG : M_P_MONO;
      default: m = '0;
    endcase
    return is_long ? '0 : m;
  endfunction

endpackage

// ----- hw/rtl/fma_parser.sv -----
// Character parser: tracks the pending atom token and issues atoms to be weighed.
module fma_parser
  import fma_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_ch,
  input  logic            in_last,
  input  logic            mass_kind,
  input  logic            heavy_nitrogen,
  output logic            cmt_valid,
  input  logic            cmt_ready,
  output commit_t         cmt
);

  phase_t                phase_r, phase_nxt;
  logic [7:0]            first_r, first_nxt;
  logic                  long_r, long_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  seen_r, seen_nxt;
  logic                  cmt_valid_r, cmt_valid_nxt;
  commit_t               cmt_r, cmt_nxt;
  logic [COUNT_BITS+3:0] count_x10;
  logic                  accept;

  assign in_ready  = !cmt_valid_r || cmt_ready;
  assign accept    = in_valid && in_ready;
  assign cmt_valid = cmt_valid_r;
  assign cmt       = cmt_r;

  assign count_x10 = ({4'b0, count_r} << 3) + ({4'b0, count_r} << 1)
                   + {{COUNT_BITS{1'b0}}, in_ch[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    long_nxt  = long_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    cmt_nxt   = '0;
    cmt_nxt.last = in_last;
    case (phase_r)
      PH_IDLE: begin
        first_nxt = in_ch;
        long_nxt  = 1'b0;
        count_nxt = '0;
        seen_nxt  = 1'b0;
        phase_nxt = PH_NAME;
      end
      PH_NAME, PH_COUNT: begin
        if (phase_r == PH_NAME && is_lower(in_ch)) begin
          long_nxt = 1'b1;
        end else if (phase_r == PH_NAME && is_digit(in_ch)) begin
          seen_nxt  = 1'b1;
          count_nxt = COUNT_BITS'(in_ch[3:0]);
          phase_nxt = PH_COUNT;
        end else if (phase_r == PH_COUNT && is_digit(in_ch)) begin
          if (count_x10 > {4'b0, COUNT_MAX}) begin
            count_nxt   = COUNT_MAX;
            cmt_nxt.ovf = 1'b1;
          end else begin
            count_nxt = count_x10[COUNT_BITS-1:0];
          end
        end else begin
          cmt_nxt.mass_a  = mass_lookup(first_r, long_r, mass_kind, heavy_nitrogen);
          cmt_nxt.count_a = seen_r ? count_r : COUNT_BITS'(1);
          if (is_upper(in_ch) || is_lower(in_ch)) begin
            first_nxt = in_ch;
            long_nxt  = 1'b0;
            count_nxt = '0;
            seen_nxt  = 1'b0;
            phase_nxt = PH_NAME;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (is_upper(in_ch) || is_lower(in_ch)) begin
          first_nxt = in_ch;
          long_nxt  = 1'b0;
          count_nxt = '0;
          seen_nxt  = 1'b0;
          phase_nxt = PH_NAME;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (in_last) begin
      if (phase_nxt == PH_NAME || phase_nxt == PH_COUNT) begin
        cmt_nxt.mass_b  = mass_lookup(first_nxt, long_nxt, mass_kind, heavy_nitrogen);
        cmt_nxt.count_b = seen_nxt ? count_nxt : COUNT_BITS'(1);
      end
      phase_nxt = PH_IDLE;
      first_nxt = '0;
      long_nxt  = 1'b0;
      count_nxt = '0;
      seen_nxt  = 1'b0;
    end
  end

  always_comb begin
    cmt_valid_nxt = cmt_valid_r;
    if (accept) begin
      cmt_valid_nxt = 1'b1;
    end else if (cmt_ready) begin
      cmt_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      first_r     <= '0;
      long_r      <= 1'b0;
      count_r     <= '0;
      seen_r      <= 1'b0;
      cmt_valid_r <= 1'b0;
    end else begin
      cmt_valid_r <= cmt_valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        first_r <= first_nxt;
        long_r  <= long_nxt;
        count_r <= count_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmt_r <= cmt_nxt;
    end
  end

endmodule

// ----- hw/rtl/fma_mult.sv -----
// Multiplier stage: weighs each issued atom by its count.
module fma_mult
  import fma_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmt_valid,
  output logic     cmt_ready,
  input  commit_t  cmt,
  output logic     prd_valid,
  input  logic     prd_ready,
  output product_t prd
);

  logic     prd_valid_r, prd_valid_nxt;
  product_t prd_r, prd_nxt;
  logic     accept;

  assign cmt_ready = !prd_valid_r || prd_ready;
  assign accept    = cmt_valid && cmt_ready;
  assign prd_valid = prd_valid_r;
  assign prd       = prd_r;

  always_comb begin
    prd_nxt.prod_a = PROD_BITS'(cmt.mass_a) * PROD_BITS'(cmt.count_a);
    prd_nxt.prod_b = PROD_BITS'(cmt.mass_b) * PROD_BITS'(cmt.count_b);
    prd_nxt.last   = cmt.last;
    prd_nxt.ovf    = cmt.ovf;
    prd_valid_nxt  = prd_valid_r;
    if (accept) begin
      prd_valid_nxt = 1'b1;
    end else if (prd_ready) begin
      prd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_valid_r <= 1'b0;
    end else begin
      prd_valid_r <= prd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prd_r <= prd_nxt;
    end
  end

endmodule

// ----- hw/rtl/fma_accum.sv -----
// Saturating accumulator and result register.
module fma_accum
  import fma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  prd_valid,
  output logic                  prd_ready,
  input  product_t              prd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TOTAL_BITS-1:0] out_total_mass,
  output logic                  out_overflow
);

  logic [TOTAL_BITS-1:0]    total_r, total_nxt;
  logic                     sticky_r, sticky_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [TOTAL_BITS-1:0]    out_total_mass_r;
  logic                     out_overflow_r;
  logic [PROD_EXT_BITS-1:0] pa_ext, pb_ext;
  logic                     pa_big, pb_big;
  logic [TOTAL_BITS-1:0]    pa_c, pb_c;
  logic [SUM_BITS-1:0]      sum;
  logic                     sum_big;
  logic                     accept;

  assign prd_ready      = !prd.last || !out_valid_r || out_ready;
  assign accept         = prd_valid && prd_ready;
  assign out_valid      = out_valid_r;
  assign out_total_mass = out_total_mass_r;
  assign out_overflow   = out_overflow_r;

  always_comb begin
    pa_ext  = PROD_EXT_BITS'(prd.prod_a);
    pb_ext  = PROD_EXT_BITS'(prd.prod_b);
    pa_big  = pa_ext > PROD_EXT_BITS'(TOTAL_MAX);
    pb_big  = pb_ext > PROD_EXT_BITS'(TOTAL_MAX);
    pa_c    = pa_big ? TOTAL_MAX : pa_ext[TOTAL_BITS-1:0];
    pb_c    = pb_big ? TOTAL_MAX : pb_ext[TOTAL_BITS-1:0];
    sum     = SUM_BITS'(total_r) + SUM_BITS'(pa_c) + SUM_BITS'(pb_c);
    sum_big = sum > SUM_BITS'(TOTAL_MAX);
    total_nxt  = sum_big ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
    sticky_nxt = sticky_r | prd.ovf | pa_big | pb_big | sum_big;
    out_valid_nxt = out_valid_r;
    if (accept && prd.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        if (prd.last) begin
          total_r  <= '0;
          sticky_r <= 1'b0;
        end else begin
          total_r  <= total_nxt;
          sticky_r <= sticky_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && prd.last) begin
      out_total_mass_r <= total_nxt;
      out_overflow_r   <= sticky_nxt;
    end
  end

endmodule

// ----- hw/rtl/formula_mass_accumulator_unit.sv -----
// Top level of the formula mass accumulator: configuration registers and the three stages.
// The block takes one formula character per clock cycle and never stalls the input while the
// result side is taking its beats; its three stages (parser, multiplier, accumulator) each hold
// one beat. The result of a formula passes from the parser register through the multiplier
// register into the output register after its last character is accepted and stays there until
// taken. The input is held back only when the result register still holds an untaken total and
// a further last character has reached the accumulator. Configuration writes take effect at the
// next clock edge and must only be made while no formula is in flight.
module formula_mass_accumulator_unit
  import fma_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_ch,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [TOTAL_BITS-1:0]    out_total_mass,
  output logic                     out_overflow
);

  logic     mass_kind_r;
  logic     heavy_nitrogen_r;
  logic     cmt_valid, cmt_ready;
  commit_t  cmt;
  logic     prd_valid, prd_ready;
  product_t prd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_kind_r      <= 1'b0;
      heavy_nitrogen_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASS_KIND:      mass_kind_r      <= cfg_wdata[0];
        REG_HEAVY_NITROGEN: heavy_nitrogen_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  fma_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .mass_kind      (mass_kind_r),
    .heavy_nitrogen (heavy_nitrogen_r),
    .cmt_valid      (cmt_valid),
    .cmt_ready      (cmt_ready),
    .cmt            (cmt)
  );

  fma_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmt_valid (cmt_valid),
    .cmt_ready (cmt_ready),
    .cmt       (cmt),
    .prd_valid (prd_valid),
    .prd_ready (prd_ready),
    .prd       (prd)
  );

  fma_accum u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .prd_valid      (prd_valid),
    .prd_ready      (prd_ready),
    .prd            (prd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_total_mass (out_total_mass),
    .out_overflow   (out_overflow)
  );

endmodule

// ----- hw/rtl/fma_checker.sv -----
// Port-level checks for the formula mass accumulator, bound to the top level.
module fma_checker
  import fma_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [TOTAL_BITS-1:0]    out_total_mass,
  input logic                     out_overflow
);

  // A result that has not been taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_mass) && $stable(out_overflow))
    else $error("result beat changed before it was taken");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // With the result register empty, nothing in the pipeline may hold the input back.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled without a waiting result beat");

endmodule

bind formula_mass_accumulator_unit fma_checker u_fma_checker (.*);
